@@ design/cstl_pkg.sv @@
// Shared types and constants for the CD sector-to-track locator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cstl_pkg;

  localparam int MAX_TRACKS_DEF = 128;

  localparam logic [11:0] LONG_SECTOR  = 12'd2352;
  localparam logic [11:0] SHORT_SECTOR = 12'd2048;
  localparam logic [31:0] HEADER_SKIP  = 32'd16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_AUDIO = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC
  } lk_state_t;

  // One track table entry.
  typedef struct packed {
    logic [23:0] start;
    logic [23:0] count;
    logic [31:0] offset;
    logic        short_flag;
    logic [6:0]  file;
  } entry_t;

  // Scan token handed from cell to cell, carrying the best entry so far.
  typedef struct packed {
    logic   valid;
    logic   run;
    logic   found;
    entry_t ent;
  } scan_tok_t;

  // One lookup result.
  typedef struct packed {
    logic [6:0]  track_index;
    logic        in_range;
    logic [6:0]  src_file;
    logic [31:0] byte_offset;
    logic [11:0] read_length;
    logic [23:0] relative_sector;
  } result_t;

endpackage

`default_nettype wire

@@ design/cd_sector_to_track_locator_top.sv @@
// Top level of the CD sector-to-track locator: handshake, control, cell chain and result path.
// Depends on cstl_pkg, cstl_cell and cstl_resolve.
`default_nettype none

// The block holds a table of up to MAX_TRACKS disc tracks, one entry per cell in a
// row of identical cells, and maps an absolute sector to the track, file and byte
// offset to read. A write transfer (cmd write) stores an entry in the cell named by
// entry_index and gives no result; indexes at or above MAX_TRACKS and the unused
// cmd code are dropped. A lookup transfer (audio or data) launches a scan token at
// cell 0 which steps one cell per clock down the chain; each cell either takes over
// the token with its own entry or ends the run, and the hint cell may restart it,
// so the token leaves the last cell holding the last qualifying entry. A lookup
// therefore passes the launch register, the cell chain and three stages of offset
// arithmetic before the result is loaded, once the output register is free; one lookup
// is in flight at a time. The output register holds a finished result while the
// next transfer is taken. track_count must be written through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce this. Values above MAX_TRACKS
// act as MAX_TRACKS. Table entries have no reset value.
module cd_sector_to_track_locator_top import cstl_pkg::*; #(
  parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // entry_index[6:0], entry_start_sector[30:7], entry_sector_count[54:31],
  // entry_file_offset[86:55], entry_short_sectors[87], entry_file[94:88],
  // sector_address[118:95], zero pad[119]
  input  wire logic [119:0] in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]   in_tuser,
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // track_index[6:0], in_range[7], src_file[14:8], byte_offset[46:15],
  // read_length[58:47], relative_sector[82:59], zero pad[87:83]
  output logic [87:0]       out_tdata,
  // configuration
  input  wire logic         cfg_wr_en,
  input  wire logic [7:0]   cfg_wr_data
);

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  lk_state_t        state_r, state_nxt;
  logic [7:0]       count_r;
  logic [IDX_W-1:0] hint_r;
  logic [23:0]      sector_r;
  logic             audio_r;
  logic             launch_r;

  logic             in_acc, wr_acc, lk_acc;
  cmd_t             cmd;
  entry_t           wr_entry;
  logic [6:0]       wr_idx;

  scan_tok_t        tok [0:MAX_TRACKS];
  logic [IDX_W-1:0] tok_idx [0:MAX_TRACKS];
  logic [MAX_TRACKS:0] tok_valid_vec;
  logic             chain_done;

  logic             res_valid, out_free, out_load;
  result_t          res;
  logic             out_tvalid_r;
  result_t          out_res_r;

  // Unpack the input transfer.
  always_comb begin
    cmd                 = cmd_t'(in_tuser);
    wr_idx              = in_tdata[6:0];
    wr_entry.start      = in_tdata[30:7];
    wr_entry.count      = in_tdata[54:31];
    wr_entry.offset     = in_tdata[86:55];
    wr_entry.short_flag = in_tdata[87];
    wr_entry.file       = in_tdata[94:88];
  end

  assign in_acc = in_tvalid && in_tready;
  assign wr_acc = in_acc && (cmd == CMD_WRITE);
  assign lk_acc = in_acc && ((cmd == CMD_AUDIO) || (cmd == CMD_DATA));

  // Control state machine: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (lk_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_done) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (res_valid && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state machine: outputs.
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: in_tready = 1'b0;
      ST_CALC: out_load  = res_valid && out_free;
      default: in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= 8'd0;
      hint_r   <= '0;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= lk_acc;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      // Park the hint on the hit, or on entry 0 when nothing matched.
      if (chain_done) begin
        hint_r <= tok[MAX_TRACKS].found ? tok_idx[MAX_TRACKS] : '0;
      end
    end
  end

  // Hold the lookup operands for the whole scan.
  always_ff @(posedge clk) begin
    if (lk_acc) begin
      sector_r <= in_tdata[118:95];
      audio_r  <= (cmd == CMD_AUDIO);
    end
  end

  // Token entering cell 0: a run opens at cell 0, nothing found yet.
  assign tok[0]     = '{valid: launch_r, run: 1'b1, found: 1'b0, ent: '0};
  assign tok_idx[0] = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_TRACKS; k++) begin : g_cell
      cstl_cell #(
        .IDX_W    (IDX_W),
        .CELL_IDX (k)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_acc),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .sector   (sector_r),
        .hint     (hint_r),
        .count    (count_r),
        .tok_in   (tok[k]),
        .idx_in   (tok_idx[k]),
        .tok_out  (tok[k+1]),
        .idx_out  (tok_idx[k+1])
      );
    end
    for (k = 0; k <= MAX_TRACKS; k++) begin : g_vld
      assign tok_valid_vec[k] = tok[k].valid;
    end
  endgenerate

  assign chain_done = tok[MAX_TRACKS].valid;

  cstl_resolve #(
    .IDX_W (IDX_W)
  ) u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (chain_done),
    .found     (tok[MAX_TRACKS].found),
    .idx       (tok_idx[MAX_TRACKS]),
    .ent       (tok[MAX_TRACKS].ent),
    .sector    (sector_r),
    .audio     (audio_r),
    .ack       (out_load),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: free when empty or when its transfer completes this cycle.
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_res_r.relative_sector, out_res_r.read_length,
                       out_res_r.byte_offset, out_res_r.src_file,
                       out_res_r.in_range, out_res_r.track_index};

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid_vec))
    else $error("more than one scan token in the chain");

  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain_done |-> (state_r == ST_SCAN))
    else $error("scan finished outside the scan state");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!(|tok_valid_vec[MAX_TRACKS:1]) && !res_valid))
    else $error("lookup still in flight while accepting transfers");

  a_lookup_launch: assert property (@(posedge clk) disable iff (!rst_n)
    lk_acc |=> (launch_r && (state_r == ST_SCAN)))
    else $error("accepted lookup did not launch a scan");
`endif

endmodule

`default_nettype wire

@@ design/cstl_cell.sv @@
// One cell of the track table chain: holds a single entry and advances the scan token.
// Depends on cstl_pkg.
`default_nettype none

module cstl_cell import cstl_pkg::*; #(
  parameter int IDX_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [6:0]       wr_idx,
  input  wire entry_t           wr_entry,
  input  wire logic [23:0]      sector,
  input  wire logic [IDX_W-1:0] hint,
  input  wire logic [7:0]       count,
  input  wire scan_tok_t        tok_in,
  input  wire logic [IDX_W-1:0] idx_in,
  output scan_tok_t             tok_out,
  output logic [IDX_W-1:0]      idx_out
);

  localparam logic [7:0]       CELL_ID8 = 8'(CELL_IDX);
  localparam logic [IDX_W-1:0] CELL_ID  = IDX_W'(CELL_IDX);

  entry_t           ent_r;
  scan_tok_t        tok_r, tok_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             take;

  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_idx} == CELL_ID8)) begin
      ent_r <= wr_entry;
    end
  end

  // Restart at the hint cell when it qualifies, otherwise continue the running scan.
  always_comb begin
    take = tok_in.valid && (tok_in.run || (hint == CELL_ID)) &&
           (CELL_ID8 < count) && (ent_r.start <= sector);
    tok_nxt       = tok_in;
    tok_nxt.run   = take;
    tok_nxt.found = tok_in.found || take;
    idx_nxt       = idx_in;
    if (take) begin
      tok_nxt.ent = ent_r;
      idx_nxt     = CELL_ID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      tok_r.run   <= 1'b0;
      tok_r.found <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

`default_nettype wire

@@ design/cstl_resolve.sv @@
// Three-stage result pipeline: relative sector, range check and product, byte offset.
// Depends on cstl_pkg.
`default_nettype none

module cstl_resolve import cstl_pkg::*; #(
  parameter int IDX_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             found,
  input  wire logic [IDX_W-1:0] idx,
  input  wire entry_t           ent,
  input  wire logic [23:0]      sector,
  input  wire logic             audio,
  input  wire logic             ack,
  output logic                  res_valid,
  output result_t               res
);

  // stage 1
  logic             v1_r, found1_r, audio1_r;
  logic [IDX_W-1:0] idx1_r;
  entry_t           ent1_r;
  logic [23:0]      rel1_r;
  // stage 2
  logic             v2_r, found2_r, audio2_r, inside2_r, short2_r;
  logic [IDX_W-1:0] idx2_r;
  logic [6:0]       file2_r;
  logic [23:0]      rel2_r;
  logic [31:0]      prod2_r, base2_r;
  logic [31:0]      prod2_nxt, base2_nxt;
  logic [7:0]       idx8;
  // stage 3
  logic             v3_r, v3_nxt;
  result_t          res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      found1_r <= found;
      audio1_r <= audio;
      idx1_r   <= idx;
      ent1_r   <= ent;
      rel1_r   <= sector - ent.start;
    end
  end

  always_comb begin
    if (ent1_r.short_flag) begin
      prod2_nxt = 32'({rel1_r, 11'b0});
    end else begin
      prod2_nxt = 32'(rel1_r) * 32'(LONG_SECTOR);
    end
    base2_nxt = ent1_r.offset +
                ((!ent1_r.short_flag && !audio1_r) ? HEADER_SKIP : 32'd0);
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      found2_r  <= found1_r;
      audio2_r  <= audio1_r;
      inside2_r <= found1_r && (rel1_r < ent1_r.count);
      short2_r  <= ent1_r.short_flag;
      idx2_r    <= idx1_r;
      file2_r   <= ent1_r.file;
      rel2_r    <= rel1_r;
      prod2_r   <= prod2_nxt;
      base2_r   <= base2_nxt;
    end
  end

  always_comb begin
    idx8    = 8'(idx2_r);
    v3_nxt  = v3_r;
    if (v2_r) begin
      v3_nxt = 1'b1;
    end else if (ack) begin
      v3_nxt = 1'b0;
    end
    res_nxt.track_index     = found2_r ? idx8[6:0] : 7'd0;
    res_nxt.in_range        = inside2_r;
    res_nxt.src_file        = found2_r ? file2_r : 7'd0;
    res_nxt.byte_offset     = inside2_r ? (base2_r + prod2_r) : 32'd0;
    res_nxt.read_length     = (audio2_r && !(inside2_r && short2_r)) ?
                              LONG_SECTOR : SHORT_SECTOR;
    res_nxt.relative_sector = found2_r ? rel2_r : 24'd0;
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule

`default_nettype wire

@@ tb/sv/cd_sector_to_track_locator_top_tb.sv @@
// Testbench for the CD sector-to-track locator: directed rows, then random table phases.
// Depends on cstl_pkg and cd_sector_to_track_locator_top; every lookup is checked against
// an in-bench model of the track scan, or against a given result in typed directed rows.
`timescale 1ns / 1ps

module cd_sector_to_track_locator_top_tb;
  import cstl_pkg::*;

  localparam int          NUM_TRACKS   = MAX_TRACKS_DEF;
  // The settle time covers a lookup passing the chain and the offset pipeline, with a margin.
  localparam int          SETTLE_CYCLES = NUM_TRACKS + 20;
  localparam int          LIMIT_CYCLES  = 1000000;
  localparam int          ITEM_TARGET   = 1250;

  // One input transfer, in field order.
  typedef struct packed {
    cmd_t        cmd;
    logic [6:0]  idx;
    logic [23:0] start;
    logic [23:0] cnt;
    logic [31:0] off;
    logic        short_sec;
    logic [6:0]  file;
    logic [23:0] sector;
  } locator_item_t;

  // One row of the directed stimulus: a register write or an input transfer.
  typedef struct {
    bit            is_cfg;
    logic [7:0]    cfg_val;
    locator_item_t item;
    bit            typed;
    result_t       want;
  } stim_row_t;

  logic         clk;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata    = '0;
  logic [1:0]   in_tuser    = '0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [87:0]  out_tdata;
  logic         cfg_wr_en   = 1'b0;
  logic [7:0]   cfg_wr_data = '0;

  cd_sector_to_track_locator_top #(.MAX_TRACKS(NUM_TRACKS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Model state: the track table, the resume point of the scan and the count register.
  entry_t          track_tbl [NUM_TRACKS];
  int unsigned     resume_entry;
  int unsigned     count_reg;
  result_t         expected_locations [$];
  stim_row_t       directed_rows [$];

  int unsigned     errors;
  int unsigned     cycles;
  int unsigned     n_writes, n_lookups, n_ignored, n_hits, n_misses, n_phases;
  // Set for a phase to drop all idling on both sides.
  bit              calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: abort on a hang.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycles, expected_locations.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Scan for the last valid entry whose start is at or below the sector, starting from the
  // previous hit when it still qualifies, and work out where and how much to read.
  function automatic result_t locate_sector(cmd_t kind, logic [23:0] sector);
    result_t     r;
    int unsigned lim;
    int unsigned i;
    logic [23:0] rel;
    logic [31:0] size;
    logic [31:0] skip;
    entry_t      ent;
    lim = (count_reg > NUM_TRACKS) ? NUM_TRACKS : count_reg;
    i = 0;
    if (resume_entry < lim && track_tbl[resume_entry].start <= sector)
      i = resume_entry;
    while (i < lim && track_tbl[i].start <= sector)
      i++;
    r = '0;
    r.read_length = (kind == CMD_AUDIO) ? LONG_SECTOR : SHORT_SECTOR;
    if (i == 0) begin
      // Below the first track, or an empty table.
      resume_entry = 0;
      return r;
    end
    i--;
    resume_entry = i;
    ent = track_tbl[i];
    rel = sector - ent.start;
    r.track_index     = 7'(i);
    r.src_file        = ent.file;
    r.relative_sector = rel;
    r.in_range        = (rel < ent.count);
    if (r.in_range) begin
      if (ent.short_flag) begin
        size          = 32'(SHORT_SECTOR);
        skip          = 32'd0;
        r.read_length = SHORT_SECTOR;
      end else begin
        size = 32'(LONG_SECTOR);
        skip = (kind == CMD_AUDIO) ? 32'd0 : HEADER_SKIP;
      end
      r.byte_offset = ent.offset + size * 32'(rel) + skip;
    end
    return r;
  endfunction

  function automatic result_t mk_res(logic [6:0] trk, logic inr, logic [6:0] file,
                                     logic [31:0] off, logic [11:0] len, logic [23:0] rel);
    result_t r;
    r.track_index     = trk;
    r.in_range        = inr;
    r.src_file        = file;
    r.byte_offset     = off;
    r.read_length     = len;
    r.relative_sector = rel;
    return r;
  endfunction

  function automatic locator_item_t rand_item(cmd_t c);
    locator_item_t it;
    it.cmd       = c;
    it.idx       = 7'($urandom);
    it.start     = 24'($urandom);
    it.cnt       = 24'($urandom);
    it.off       = $urandom;
    it.short_sec = 1'($urandom);
    it.file      = 7'($urandom);
    it.sector    = 24'($urandom);
    return it;
  endfunction

  function automatic void row_lookup(cmd_t c, logic [23:0] sector, bit typed, result_t want);
    stim_row_t row;
    row.is_cfg      = 1'b0;
    row.cfg_val     = '0;
    row.item        = rand_item(c);
    row.item.sector = sector;
    row.typed       = typed;
    row.want        = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_write(logic [6:0] idx, logic [23:0] start, logic [23:0] cnt,
                                    logic [31:0] off, logic sh, logic [6:0] file);
    stim_row_t row;
    row.is_cfg         = 1'b0;
    row.cfg_val        = '0;
    row.item           = rand_item(CMD_WRITE);
    row.item.idx       = idx;
    row.item.start     = start;
    row.item.cnt       = cnt;
    row.item.off       = off;
    row.item.short_sec = sh;
    row.item.file      = file;
    row.typed          = 1'b0;
    row.want           = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_cfg(logic [7:0] v);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    row.item    = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endfunction

  // Update the model for an accepted transfer and queue the result it causes, if any.
  function automatic void take_item(locator_item_t it, bit typed, result_t want);
    result_t r;
    case (it.cmd)
      CMD_WRITE: begin
        track_tbl[it.idx].start      = it.start;
        track_tbl[it.idx].count      = it.cnt;
        track_tbl[it.idx].offset     = it.off;
        track_tbl[it.idx].short_flag = it.short_sec;
        track_tbl[it.idx].file       = it.file;
        n_writes++;
      end
      CMD_AUDIO, CMD_DATA: begin
        r = locate_sector(it.cmd, it.sector);
        if (r.in_range) n_hits++;
        else n_misses++;
        expected_locations.push_back(typed ? want : r);
        n_lookups++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // Present one transfer after a random gap and hold it until accepted.
  task automatic send_item(locator_item_t it, bit typed, result_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {1'b0, it.sector, it.file, it.short_sec, it.off, it.cnt, it.start, it.idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_item(it, typed, want);
  endtask

  // Hold the input idle until every lookup has returned, then let the pipeline drain.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    count_reg = v;
  endtask

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result(logic [87:0] bus);
    result_t want;
    if (expected_locations.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual %h", $time, bus);
      errors++;
      return;
    end
    want = expected_locations.pop_front();
    cmp_field("track_index",     32'(want.track_index),     32'(bus[6:0]));
    cmp_field("in_range",        32'(want.in_range),        32'(bus[7]));
    cmp_field("src_file",        32'(want.src_file),        32'(bus[14:8]));
    cmp_field("byte_offset",     want.byte_offset,          bus[46:15]);
    cmp_field("read_length",     32'(want.read_length),     32'(bus[58:47]));
    cmp_field("relative_sector", 32'(want.relative_sector), 32'(bus[82:59]));
  endtask

  // Result side: check each transfer, then hold tready low for a random number of cycles.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_result(out_tdata);
        hold = calm ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One random phase: write a fresh table, set the count while idle, then mostly lookups
  // with stray writes and unused commands mixed in.
  task automatic run_phase(int unsigned cnt_val);
    int unsigned   n;
    int unsigned   k;
    int unsigned   looks;
    int unsigned   e;
    int unsigned   roll;
    int unsigned   span;
    bit            unsorted;
    logic [23:0]   cursor;
    logic [24:0]   sum;
    logic [23:0]   last_sector;
    locator_item_t it;
    n = (cnt_val > NUM_TRACKS) ? NUM_TRACKS : cnt_val;
    n_phases++;
    calm = ($urandom_range(0, 3) == 0);
    unsorted = ($urandom_range(0, 7) == 0);
    cursor = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000));
    for (k = 0; k < n; k++) begin
      it = rand_item(CMD_WRITE);
      it.idx = 7'(k);
      if (!unsorted) begin
        it.start = cursor;
        // Equal starts now and then; saturate at the top of the sector range.
        sum = {1'b0, cursor} + (($urandom_range(0, 4) == 0) ? 25'd0 :
                                25'($urandom_range(1, 5000)));
        cursor = sum[24] ? 24'hFFFFFF : sum[23:0];
      end
      case ($urandom_range(0, 5))
        0:       it.cnt = 24'd0;
        1:       it.cnt = 24'hFFFFFF;
        default: it.cnt = 24'($urandom_range(1, 6000));
      endcase
      send_item(it, 1'b0, '0);
    end
    settle();
    write_count(8'(cnt_val));
    looks = (n == 0) ? 5 : $urandom_range(20, 50);
    last_sector = (n == 0) ? 24'd0 : track_tbl[0].start;
    while (looks > 0) begin
      roll = $urandom_range(0, 19);
      if (roll < 2) begin
        // Stray write anywhere in the table; the entry is fully written either way.
        send_item(rand_item(CMD_WRITE), 1'b0, '0);
      end else if (roll == 2) begin
        send_item(rand_item(CMD_NONE), 1'b0, '0);
      end else begin
        it = rand_item(($urandom_range(0, 1) == 0) ? CMD_AUDIO : CMD_DATA);
        roll = $urandom_range(0, 9);
        if (n == 0 || roll == 0) begin
          it.sector = 24'($urandom);
        end else if (roll == 1) begin
          // At or just below the first track.
          span = $urandom_range(0, 3);
          it.sector = (track_tbl[0].start > span) ? track_tbl[0].start - 24'(span) : 24'd0;
        end else if (roll <= 3) begin
          // Next sector in sequence, so the scan resumes from the previous hit.
          it.sector = last_sector + 24'd1;
        end else begin
          e = $urandom_range(0, n - 1);
          span = (track_tbl[e].count > 8000) ? 8000 : track_tbl[e].count + 3;
          sum = {1'b0, track_tbl[e].start} + 25'($urandom_range(0, span));
          it.sector = sum[24] ? 24'hFFFFFF : sum[23:0];
        end
        last_sector = it.sector;
        send_item(it, 1'b0, '0);
        looks--;
      end
    end
    settle();
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned first_counts [4];
    errors = 0;
    n_writes = 0; n_lookups = 0; n_ignored = 0; n_hits = 0; n_misses = 0; n_phases = 0;
    resume_entry = 0;
    count_reg = 0;
    calm = 1'b0;
    for (i = 0; i < NUM_TRACKS; i++) track_tbl[i] = '0;

    // Empty table straight after reset: nothing found, zero fill.
    row_lookup(CMD_AUDIO, 24'd0,      1'b1, mk_res(0, 0, 0, 0, LONG_SECTOR, 0));
    row_lookup(CMD_DATA,  24'hFFFFFF, 1'b1, mk_res(0, 0, 0, 0, SHORT_SECTOR, 0));
    row_write(7'd0,   24'd0,      24'd100,    32'd0,        1'b0, 7'd0);
    row_write(7'd1,   24'd150,    24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 7'd127);
    row_write(7'd2,   24'hFFFFFF, 24'd1,      32'h1000,     1'b0, 7'd5);
    row_write(7'd127, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 7'd127);
    row_lookup(CMD_NONE, 24'd0, 1'b0, '0);
    row_cfg(8'd3);
    // Long track, audio then data (16-byte header skip).
    row_lookup(CMD_AUDIO, 24'd0,   1'b1, mk_res(0, 1, 0, 0,  LONG_SECTOR,  0));
    row_lookup(CMD_DATA,  24'd0,   1'b1, mk_res(0, 1, 0, 16, SHORT_SECTOR, 0));
    // Past the end of track 0.
    row_lookup(CMD_AUDIO, 24'd120, 1'b1, mk_res(0, 0, 0, 0,  LONG_SECTOR,  120));
    // Short track at the largest offset.
    row_lookup(CMD_DATA,  24'd150, 1'b1,
               mk_res(1, 1, 7'd127, 32'hFFFFFFFF, SHORT_SECTOR, 0));
    row_lookup(CMD_AUDIO, 24'd151, 1'b0, '0);
    row_lookup(CMD_DATA,  24'd160, 1'b0, '0);
    row_lookup(CMD_AUDIO, 24'hFFFFFF, 1'b0, '0);
    row_lookup(CMD_DATA,  24'd99,  1'b0, '0);
    row_lookup(CMD_DATA,  24'hFFFFFF, 1'b1, mk_res(2, 1, 5, 32'h1010, SHORT_SECTOR, 0));
    // Move the first track up, then ask below it, inside it and just past its end.
    row_write(7'd0, 24'd10, 24'd5, 32'h100, 1'b0, 7'd3);
    row_lookup(CMD_DATA,  24'd3,   1'b1, mk_res(0, 0, 0, 0, SHORT_SECTOR, 0));
    row_lookup(CMD_AUDIO, 24'd14,  1'b0, '0);
    row_lookup(CMD_AUDIO, 24'd15,  1'b1, mk_res(0, 0, 3, 0, LONG_SECTOR, 5));
    row_cfg(8'd0);
    row_lookup(CMD_AUDIO, 24'd150, 1'b1, mk_res(0, 0, 0, 0, LONG_SECTOR, 0));
    row_lookup(CMD_NONE,  24'd0,   1'b0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        settle();
        write_count(directed_rows[r].cfg_val);
      end else begin
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end
    end
    settle();

    // Full table, counts above the table size, and an empty table first; then mostly
    // small tables with the odd large one.
    first_counts = '{128, 255, 129, 0};
    foreach (first_counts[c]) run_phase(first_counts[c]);
    while (n_writes + n_lookups < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) run_phase($urandom_range(17, 128));
      else run_phase($urandom_range(1, 16));
    end

    in_tvalid <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_locations.size() != 0) errors++;

    $display("Covered %0d lookups (%0d in range, %0d zero fill), %0d table writes,",
             n_lookups, n_hits, n_misses, n_writes);
    $display("%0d unused commands, over %0d table settings, %0d cycles.",
             n_ignored, n_phases + 2, cycles);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
